// ----- sv/rlbm_pkg.sv -----
// rlbm_pkg: types, constants and register indexes of the run-length to bitmap line block
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package rlbm_pkg;

  // defaults of the top-level parameters
  localparam int unsigned DEF_MAX_LINE_WIDTH = 2048;
  localparam int unsigned DEF_MAX_PAGE_ROWS  = 4096;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RESULT_CAP  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] REG_LINE_WIDTH      = 3'd0;
  localparam logic [2:0] REG_PAGE_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_INVERT_COLORS   = 3'd2;
  localparam logic [2:0] REG_FINE_RESOLUTION = 3'd3;
  localparam logic [2:0] REG_STRIP_FIRST_ROW = 3'd4;

  // reset values of the configuration registers
  localparam logic [11:0] RST_LINE_WIDTH  = 12'd1728;
  localparam logic [12:0] RST_PAGE_HEIGHT = 13'd2339;

  typedef struct packed {
    logic [15:0] run_length;
    logic [11:0] row_in_strip;
    logic        line_start;
  } item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [5:0]  word_index;
    logic [12:0] output_row;
    logic        also_next_row;
    logic        line_complete;
    logic        last_of_item;
  } result_t;

  typedef struct packed {
    logic [11:0] line_width;
    logic [12:0] page_height;
    logic        invert_colors;
    logic        fine_resolution;
    logic [11:0] strip_first_row;
  } cfg_t;

  // one item's output work, handed from front to back
  typedef struct packed {
    logic        head_valid;
    logic [31:0] head_word;
    logic        tail_valid;
    logic [31:0] tail_word;
    logic        fill_color;
    logic [5:0]  last_idx;
    logic [5:0]  first_index;
    logic [12:0] output_row;
    logic        also_next_row;
    logic        line_end;
  } cmd_t;

endpackage

// ----- sv/rlbm_front.sv -----
// rlbm_front: takes runs, keeps packing state, turns each run into at most one command
// depends on rlbm_pkg
`timescale 1ns / 1ps

module rlbm_front #(
  parameter int unsigned MAX_LINE_WIDTH = rlbm_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_PAGE_ROWS  = rlbm_pkg::DEF_MAX_PAGE_ROWS
) (
  input  logic           clk,
  input  logic           rst,
  input  rlbm_pkg::cfg_t  cfg,
  input  rlbm_pkg::item_t item,
  input  logic           accept,
  output rlbm_pkg::cmd_t  cmd,
  output logic           cmd_push
);
  import rlbm_pkg::*;

  logic [31:0] partial_word, partial_word_next;
  logic [4:0]  bits_filled, bits_filled_next;
  logic        current_color, current_color_next;
  logic [11:0] pixels_done, pixels_done_next;
  logic [6:0]  words_written, words_written_next;
  logic        line_active, line_active_next;
  logic [12:0] current_row, current_row_next;

  // state as seen after a line start
  logic [31:0] pw0;
  logic [4:0]  bf0;
  logic        col0;
  logic [11:0] pd0;
  logic [6:0]  ws0;
  logic        act0;
  logic [12:0] row0;

  logic [12:0] row_sum;
  logic [11:0] w_eff;
  logic        row_ok;
  logic [16:0] tot, sum, rem, fills, total;
  logic        over, at_end, ended, head, tail;
  logic [31:0] mask, merged, fill_word;
  logic [4:0]  bf_new;
  logic [6:0]  cnt;

  always_comb begin
    row_sum = 13'(item.row_in_strip) + 13'(cfg.strip_first_row);
    w_eff   = (int'(cfg.line_width) < int'(MAX_LINE_WIDTH)) ? cfg.line_width
                                                            : 12'(MAX_LINE_WIDTH);
    row_ok  = (row_sum < cfg.page_height) && (int'(row_sum) < int'(MAX_PAGE_ROWS)) &&
              (w_eff != '0);

    pw0  = partial_word;
    bf0  = bits_filled;
    col0 = current_color;
    pd0  = pixels_done;
    ws0  = words_written;
    act0 = line_active;
    row0 = current_row;
    if (item.line_start) begin
      act0 = row_ok;
      if (row_ok) begin
        pw0  = '0;
        bf0  = '0;
        col0 = cfg.invert_colors;
        pd0  = '0;
        ws0  = '0;
        row0 = row_sum;
      end
    end

    tot    = 17'(pd0) + 17'(item.run_length);
    over   = tot > 17'(w_eff);
    at_end = tot == 17'(w_eff);
    ended  = over || at_end;

    // colour the bits past the fill point with the run's colour
    mask      = 32'hFFFF_FFFF >> bf0;
    merged    = col0 ? (pw0 | mask) : (pw0 & ~mask);
    fill_word = {WORD_W{col0}};

    sum    = 17'(bf0) + 17'(item.run_length);
    head   = !over && (sum >= 17'(WORD_W));
    rem    = sum - 17'(WORD_W);
    fills  = head ? (rem >> 5) : '0;
    bf_new = head ? rem[4:0] : sum[4:0];
    tail   = ended && (over ? (bf0 != '0) : (bf_new != '0));

    total = 17'(head) + fills + 17'(tail);
    cnt   = (total > 17'(RESULT_CAP)) ? 7'(RESULT_CAP) : total[6:0];

    cmd.head_valid    = head;
    cmd.head_word     = merged;
    cmd.tail_valid    = tail && (total <= 17'(RESULT_CAP));
    cmd.tail_word     = over ? pw0 : (head ? fill_word : merged);
    cmd.fill_color    = col0;
    cmd.last_idx      = 6'(cnt - 7'd1);
    cmd.first_index   = ws0[5:0];
    cmd.output_row    = cfg.fine_resolution ? row0 : {row0[11:0], 1'b0};
    cmd.also_next_row = !cfg.fine_resolution;
    cmd.line_end      = ended;

    cmd_push = accept && act0 && (cnt != '0);

    partial_word_next  = pw0;
    bits_filled_next   = bf0;
    current_color_next = col0;
    pixels_done_next   = pd0;
    words_written_next = ws0;
    line_active_next   = act0;
    current_row_next   = row0;
    if (act0) begin
      line_active_next   = !ended;
      bits_filled_next   = ended ? '0 : bf_new;
      words_written_next = ws0 + cnt;
      if (!over) begin
        pixels_done_next   = tot[11:0];
        current_color_next = ~col0;
        partial_word_next  = head ? fill_word : merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word  <= '0;
      bits_filled   <= '0;
      current_color <= 1'b0;
      pixels_done   <= '0;
      words_written <= '0;
      line_active   <= 1'b0;
      current_row   <= '0;
    end else if (accept) begin
      partial_word  <= partial_word_next;
      bits_filled   <= bits_filled_next;
      current_color <= current_color_next;
      pixels_done   <= pixels_done_next;
      words_written <= words_written_next;
      line_active   <= line_active_next;
      current_row   <= current_row_next;
    end
  end

endmodule

// ----- sv/rlbm_queue.sv -----
// rlbm_queue: short command queue between front and back
// depends on rlbm_pkg
`timescale 1ns / 1ps

module rlbm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rlbm_pkg::cmd_t wdata,
  input  logic          pop,
  output rlbm_pkg::cmd_t rdata,
  output logic          q_empty,
  output logic          q_full
);
  import rlbm_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign q_empty = (count == '0);
  assign q_full  = (count == CntW'(QUEUE_DEPTH));
  assign rdata   = entries[rd_ptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rlbm_back.sv -----
// rlbm_back: walks one command word by word into the output register
// depends on rlbm_pkg
`timescale 1ns / 1ps

module rlbm_back (
  input  logic             clk,
  input  logic             rst,
  input  rlbm_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  logic             pop,
  output rlbm_pkg::result_t result,
  output logic             empty
);
  import rlbm_pkg::*;

  logic [5:0]  idx;
  logic        out_valid;
  logic        can_load, load, last;
  logic [31:0] word;

  always_comb begin
    can_load = !out_valid || pop;
    load     = cmd_valid && can_load;
    last     = (idx == cmd.last_idx);
    // head word first, tail word last, solid fill in between
    if (idx == '0 && cmd.head_valid) begin
      word = cmd.head_word;
    end else if (last && cmd.tail_valid) begin
      word = cmd.tail_word;
    end else begin
      word = {WORD_W{cmd.fill_color}};
    end
    cmd_pop = load && last;
    empty   = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? '0 : idx + 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.pixel_word    <= word;
      result.word_index    <= cmd.first_index + idx;
      result.output_row    <= cmd.output_row;
      result.also_next_row <= cmd.also_next_row;
      result.line_complete <= last && cmd.line_end;
      result.last_of_item  <= last;
    end
  end

endmodule

// ----- sv/run_length_to_bitmap_line.sv -----
// run_length_to_bitmap_line: top level, configuration registers, front/queue/back wiring
// depends on rlbm_pkg, rlbm_front, rlbm_queue, rlbm_back
`timescale 1ns / 1ps

// usage
// - input side is a queue: drive item and raise push; the run is taken at an edge
//   where push is high and full is low; runs of a line alternate colour from line start
// - result side is a queue: while empty is low the oldest packed word sits on result;
//   it is taken at an edge where pop is high
// - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high; write only while the block is idle
// flow and throughput
// - a run is classified in the cycle it is taken; its command passes the command queue
//   and the back end's output register before its first word shows on result, then
//   one word per cycle follows while pop keeps up
// - one run per cycle is taken while the two-entry command queue has room; a run
//   with no word pushes no command, one with words holds the back end to its last word
// reset
// - registers return to their defaults, no line is open, queue and output are empty
// stall
// - with pop low the output register holds its word, the back end waits, the queue
//   fills and full rises; nothing is dropped
module run_length_to_bitmap_line #(
  parameter int unsigned MAX_LINE_WIDTH = rlbm_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_PAGE_ROWS  = rlbm_pkg::DEF_MAX_PAGE_ROWS
) (
  input  logic             clk,
  input  logic             rst,
  // run input
  input  rlbm_pkg::item_t   item,
  input  logic             push,
  output logic             full,
  // word output
  output rlbm_pkg::result_t result,
  output logic             empty,
  input  logic             pop,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import rlbm_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in, cmd_out;
  logic accept, cmd_push, cmd_pop, q_empty;

  // configuration registers, read live by the front end
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width      <= RST_LINE_WIDTH;
      cfg.page_height     <= RST_PAGE_HEIGHT;
      cfg.invert_colors   <= 1'b0;
      cfg.fine_resolution <= 1'b0;
      cfg.strip_first_row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:      cfg.line_width      <= cfg_data[11:0];
        REG_PAGE_HEIGHT:     cfg.page_height     <= cfg_data[12:0];
        REG_INVERT_COLORS:   cfg.invert_colors   <= cfg_data[0];
        REG_FINE_RESOLUTION: cfg.fine_resolution <= cfg_data[0];
        REG_STRIP_FIRST_ROW: cfg.strip_first_row <= cfg_data[11:0];
        default: ; // unmapped index, write ignored
      endcase
    end
  end

  // the front takes a run whenever the command queue has a free slot
  assign accept = push && !full;

  rlbm_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .MAX_PAGE_ROWS (MAX_PAGE_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .accept  (accept),
    .cmd     (cmd_in),
    .cmd_push(cmd_push)
  );

  // commands wait here so front and back stall independently
  rlbm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wdata  (cmd_in),
    .pop    (cmd_pop),
    .rdata  (cmd_out),
    .q_empty(q_empty),
    .q_full (full)
  );

  // back end: head, fill and tail words, one per cycle to the output while pop keeps up
  rlbm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .cmd_valid(!q_empty),
    .cmd_pop  (cmd_pop),
    .pop      (pop),
    .result   (result),
    .empty    (empty)
  );

  // a full queue means the back end has a word waiting at the output
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("command queue full with no word at the output");

  // end of line only marks an item's final word
  a_line_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.line_complete) |-> result.last_of_item)
    else $error("line_complete on a word that is not the last of its item");

  // words of one item follow back to back with consecutive positions
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_of_item) |=>
      (!empty && result.word_index == 6'($past(result.word_index) + 6'd1)))
    else $error("word positions within an item are not consecutive");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for run_length_to_bitmap_line, queue-style run and word ports
// depends on rlbm_pkg and run_length_to_bitmap_line; predicts packed words from its own model
`timescale 1ns / 1ps

module tb_top;
  import rlbm_pkg::*;

  localparam int unsigned RANDOM_RUNS  = 350;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 50;

  // predicts the packed words of each accepted run and checks them in order
  class bitmap_scoreboard;
    // register copies, updated as writes land
    bit [11:0] line_width;
    bit [12:0] page_height;
    bit        invert_colors;
    bit        fine_resolution;
    bit [11:0] strip_first_row;
    // packing state of the open line
    bit [31:0]   partial_word;
    int unsigned bits_filled;
    int unsigned pixels_done;
    bit          current_color;
    bit          line_active;
    bit [6:0]    words_written;
    bit [11:0]   current_row;
    result_t     expected_words[$];
    result_t     run_words[$];
    int unsigned errors;
    int unsigned runs_used;

    function new();
      line_width      = RST_LINE_WIDTH;
      page_height     = RST_PAGE_HEIGHT;
      invert_colors   = 1'b0;
      fine_resolution = 1'b0;
      strip_first_row = '0;
      partial_word    = '0;
      bits_filled     = 0;
      pixels_done     = 0;
      current_color   = 1'b0;
      line_active     = 1'b0;
      words_written   = '0;
      current_row     = '0;
      errors          = 0;
      runs_used       = 0;
    endfunction

    function int unsigned eff_width();
      return (line_width < DEF_MAX_LINE_WIDTH) ? line_width : DEF_MAX_LINE_WIDTH;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LINE_WIDTH:      line_width = val[11:0];
        REG_PAGE_HEIGHT:     page_height = val[12:0];
        REG_INVERT_COLORS:   invert_colors = val[0];
        REG_FINE_RESOLUTION: fine_resolution = val[0];
        REG_STRIP_FIRST_ROW: strip_first_row = val[11:0];
        default: ;
      endcase
    endfunction

    function void add_word(bit [31:0] pixels);
      result_t r;
      if (run_words.size() >= RESULT_CAP) return;
      r.pixel_word    = pixels;
      r.word_index    = words_written[5:0];
      r.output_row    = fine_resolution ? {1'b0, current_row} : {current_row, 1'b0};
      r.also_next_row = !fine_resolution;
      r.line_complete = 1'b0;
      r.last_of_item  = 1'b0;
      run_words.push_back(r);
      words_written = words_written + 1'b1;
    endfunction

    function void note_run(item_t it);
      int unsigned n, w, h, total, row, last;
      bit ended;
      bit [31:0] fill;
      n = it.run_length;
      w = eff_width();
      ended = 1'b0;
      run_words.delete();
      runs_used++;
      if (it.line_start) begin
        row = it.row_in_strip + strip_first_row;
        h = (page_height < DEF_MAX_PAGE_ROWS) ? page_height : DEF_MAX_PAGE_ROWS;
        line_active = 1'b0;
        if (row < h && w > 0) begin
          current_row   = row[11:0];
          partial_word  = '0;
          bits_filled   = 0;
          current_color = invert_colors;
          pixels_done   = 0;
          words_written = '0;
          line_active   = 1'b1;
        end
      end
      if (!line_active) return;
      total = pixels_done + n;
      if (total > w) begin
        // run would cross the line end: dropped, line closes
        ended = 1'b1;
      end else begin
        fill = current_color ? 32'hFFFF_FFFF : 32'h0;
        // paint the rest of the partial word in the run colour
        if (current_color) partial_word |= 32'hFFFF_FFFF >> bits_filled;
        else if (bits_filled != 0) partial_word &= 32'hFFFF_FFFF << (32 - bits_filled);
        else partial_word = '0;
        if (bits_filled + n < 32) begin
          bits_filled += n;
        end else begin
          add_word(partial_word);
          n -= 32 - bits_filled;
          while (n >= 32) begin
            n -= 32;
            add_word(fill);
          end
          partial_word = fill;
          bits_filled  = n;
        end
        current_color = !current_color;
        pixels_done   = total & 12'hFFF;
        if (total >= w) ended = 1'b1;
      end
      if (ended) begin
        if (bits_filled != 0) add_word(partial_word);
        bits_filled = 0;
        line_active = 1'b0;
        if (run_words.size() > 0) begin
          last = run_words.size() - 1;
          run_words[last].line_complete = 1'b1;
        end
      end
      if (run_words.size() > 0) begin
        last = run_words.size() - 1;
        run_words[last].last_of_item = 1'b1;
      end
      foreach (run_words[i]) expected_words.push_back(run_words[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = expected_words.pop_front();
      compare_field("pixel_word", want.pixel_word, got.pixel_word);
      compare_field("word_index", want.word_index, got.word_index);
      compare_field("output_row", want.output_row, got.output_row);
      compare_field("also_next_row", want.also_next_row, got.also_next_row);
      compare_field("line_complete", want.line_complete, got.line_complete);
      compare_field("last_of_item", want.last_of_item, got.last_of_item);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  item_t       run_in = '0;
  logic        push = 1'b0;
  logic        full;
  result_t     word_out;
  logic        empty;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_LINE_WIDTH;
  logic [31:0] cfg_data = '0;

  bitmap_scoreboard sb = new();

  // idle-pattern state for both sides
  int unsigned calm_left  = 0;
  int unsigned stall_left = 0;
  int unsigned flow_left  = 0;
  int unsigned pop_pick;

  run_length_to_bitmap_line dut (
    .clk       (clk),
    .rst       (rst),
    .item      (run_in),
    .push      (push),
    .full      (full),
    .result    (word_out),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // everything the block takes or gives is seen here, at the rising edge
  // inputs only move on falling edges, so these are the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_word(word_out);
      if (push && !full) sb.note_run(run_in);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // word side: mostly pops, single-cycle stalls, a few long stalls and steady stretches
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (flow_left != 0) begin
      flow_left--;
      pop <= 1'b1;
    end else begin
      pop_pick = $urandom_range(0, 99);
      if (pop_pick < 4) begin
        stall_left = $urandom_range(10, 40);
        pop <= 1'b0;
      end else if (pop_pick < 10) begin
        flow_left = $urandom_range(20, 60);
        pop <= 1'b1;
      end else begin
        pop <= (pop_pick >= 35);
      end
    end
  end

  // gap before the next run; calm stretches have no gaps at all
  function automatic int unsigned next_gap();
    int unsigned pick;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // push stays high from one run to the next when there is no gap
  task automatic send_run(int unsigned n, int unsigned row, bit start);
    int unsigned gap;
    gap = next_gap();
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    run_in.run_length   <= n[15:0];
    run_in.row_in_strip <= row[11:0];
    run_in.line_start   <= start;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // stop sending and wait until every predicted word has been popped
  task automatic drain_words();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // runs that give no word may still be in flight after the drain, so settle first
  task automatic configure(int unsigned w, int unsigned h, bit inv, bit fine,
                           int unsigned strip);
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_PAGE_HEIGHT, h);
    write_reg(REG_INVERT_COLORS, inv);
    write_reg(REG_FINE_RESOLUTION, fine);
    write_reg(REG_STRIP_FIRST_ROW, strip);
  endtask

  // run length no longer than what is left of the line, biased toward short runs
  function automatic int unsigned pick_run(int unsigned left);
    int unsigned pick;
    if (left == 0) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, (left < 8) ? left : 8);
    if (pick < 70) return $urandom_range(0, (left < 40) ? left : 40);
    if (pick < 90) return $urandom_range((left < 32) ? left : 32, (left < 100) ? left : 100);
    return $urandom_range(0, left);
  endfunction

  // one line: runs that fill it exactly, now and then one that crosses the end
  task automatic send_line();
    int unsigned w, left, n, row;
    bit first, overshoot;
    w = sb.eff_width();
    left = (w == 0) ? $urandom_range(1, 50) : w;
    row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
    overshoot = ($urandom_range(0, 9) == 0);
    first = 1'b1;
    do begin
      n = pick_run(left);
      if (overshoot && $urandom_range(0, 3) == 0) n = $urandom_range(left + 1, 65535);
      // row only matters on the line start; elsewhere it is noise
      send_run(n, first ? row : $urandom_range(0, 4095), first);
      first = 1'b0;
      if (n > left) break;
      left -= n;
    end while (left != 0);
  endtask

  // random fields: orphan runs, stray line starts, huge runs
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_run($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 1));
  endtask

  task automatic random_phase();
    int unsigned w, h, strip, pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) w = $urandom_range(1, 160);
    else if (pick < 15) w = $urandom_range(161, 2047);
    else if (pick < 17) w = 2048;
    else if (pick < 19) w = $urandom_range(2049, 4095);
    else w = 0;
    pick = $urandom_range(0, 19);
    if (pick < 12) h = 4096;
    else if (pick < 14) h = $urandom_range(4097, 8191);
    else if (pick < 17) h = $urandom_range(1, 30);
    else if (pick < 19) h = $urandom_range(31, 4095);
    else h = 0;
    strip = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
    configure(w, h, $urandom_range(0, 1), $urandom_range(0, 1), strip);
    repeat ($urandom_range(3, 12)) begin
      if ($urandom_range(0, 99) < 85) send_line();
      else send_noise();
      // sender holds off now and then until the word queue is empty
      if ($urandom_range(0, 9) == 0) drain_words();
    end
  endtask

  // directed lines first, then random phases with fresh register settings
  initial begin
    int unsigned base_runs, phases;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: 1728-pixel line, normal resolution, exact fill
    send_run(100, 5, 1'b1);
    send_run(1628, 0, 1'b0);

    // narrow fine line: orphan run, zero run at line start, exact end, crossing runs
    configure(40, 4096, 1'b0, 1'b1, 0);
    send_run(5, 0, 1'b0);
    send_run(0, 0, 1'b1);
    send_run(3, 0, 1'b0);
    send_run(37, 0, 1'b0);
    send_run(65535, 1, 1'b1);
    send_run(7, 2, 1'b1);
    send_run(33, 0, 1'b0);
    send_run(10, 3, 1'b1);
    send_run(31, 0, 1'b0);
    send_run(4, 4095, 1'b1);
    send_run(36, 0, 1'b0);

    // widest line inverted, clamped width and height, strip offset at its top
    configure(4095, 8191, 1'b1, 1'b0, 4095);
    send_run(2048, 0, 1'b1);
    send_run(1, 1, 1'b1);
    send_run(1, 0, 1'b0);
    send_run(64, 4095, 1'b1);

    // zero width opens no line
    configure(0, 4096, 1'b0, 1'b1, 0);
    send_run(1, 0, 1'b1);

    // one-pixel line on a one-row page
    configure(1, 1, 1'b1, 1'b1, 0);
    send_run(1, 0, 1'b1);
    send_run(1, 1, 1'b1);

    // zero height drops every row
    configure(32, 0, 1'b0, 1'b0, 0);
    send_run(32, 0, 1'b1);

    base_runs = sb.runs_used;
    phases = 0;
    while (sb.runs_used - base_runs < RANDOM_RUNS && phases < 80) begin
      random_phase();
      phases++;
    end

    drain_words();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("run_length_to_bitmap_line test passed");
    end else begin
      $display("run_length_to_bitmap_line test failed");
    end
    $finish;
  end

  // hard stop in case the handshakes hang
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d words still expected", $time, sb.pending());
    $display("run_length_to_bitmap_line test failed");
    $finish;
  end

endmodule
